### rtl/wmor_pkg.sv
// ----------------------------------------------------------------------------
// wmor_pkg
// Shared types and constants of the windowed mean with outlier rejection.
// ----------------------------------------------------------------------------
package wmor_pkg;

  // register field widths
  localparam int LenW      = 7;
  localparam int ThreshW   = 31;
  localparam int RestartW  = 16;
  localparam int RunW      = RestartW + 1;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = ThreshW;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgWindowLength    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRejectThreshold = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRestartAfter    = 2'd2;

  // register reset values
  localparam logic [LenW-1:0]     LenReset     = 7'd64;
  localparam logic [ThreshW-1:0]  ThreshReset  = 31'd65536;
  localparam logic [RestartW-1:0] RestartReset = 16'd3;

  typedef enum logic [2:0] {
    StIdle,
    StEval,
    StStart,
    StDiv,
    StOut
  } wmor_state_e;

endpackage

### rtl/wmor_ram.sv
// ----------------------------------------------------------------------------
// wmor_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wmor_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/wmor_div.sv
// ----------------------------------------------------------------------------
// wmor_div
// Radix-2 restoring divider: signed dividend by unsigned nonzero divisor,
// quotient truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wmor_div #(
  parameter int DividendW = 38,
  parameter int DivisorW  = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]         divisor_i,
  output logic                        done_o,
  output logic signed [DividendW-1:0] quotient_o
);

  localparam int CountW = $clog2(DividendW + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 neg_q, neg_d;
  logic [CountW-1:0]    cnt_q, cnt_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW:0]    shifted;
  logic [DivisorW:0]    trial;
  logic                 fits;

  assign shifted = {rem_q, quo_q[DividendW-1]};
  assign trial   = shifted - {1'b0, divisor_i};
  assign fits    = shifted >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = dividend_i[DividendW-1];
      quo_d  = dividend_i[DividendW-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_d  = '0;
      cnt_d  = CountW'(DividendW);
    end else if (busy_q) begin
      rem_d = fits ? trial[DivisorW-1:0] : shifted[DivisorW-1:0];
      quo_d = {quo_q[DividendW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CountW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? $signed(~quo_q + 1'b1) : $signed(quo_q);

`ifndef NO_ASSERTIONS
  // a result only comes out of a running division
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy_q))
    else $error("divider done without a running division");
  // the remainder always stays below the divisor while running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i && !$past(start_i) |-> rem_q < divisor_i)
    else $error("divider remainder out of range");
  // no new start while a division is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> !start_i)
    else $error("divider restarted while busy");
`endif

endmodule

### rtl/window_mean_outlier_reject_top.sv
// ----------------------------------------------------------------------------
// window_mean_outlier_reject_top
// Moving average over a window of Q16.16 samples with outlier rejection.
// ----------------------------------------------------------------------------
// An item that lands within the threshold of the current mean goes through
// these steps in order: accept it and read the oldest sample from the window
// memory, update the running sum and write the memory, launch the divider,
// form sum / count in the bit-serial divider one quotient bit at a time,
// take the quotient, and load the result register. A rejected item needs no
// division and goes from the update step straight to the result register.
// The next item is accepted while a result still waits in the output
// register; a finished item that finds the output register still occupied
// holds the block until that result leaves. The window memory needs no
// clearing pass after reset.
module window_mean_outlier_reject_top
  import wmor_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64,
  parameter int SAMPLE_BITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] mean_o,
  output logic                          accepted_o,
  output logic                          restarted_o,
  output logic                          window_full_o,
  input  logic                          cfg_we_i,
  input  logic [CfgIdxW-1:0]            cfg_index_i,
  input  logic [CfgDataW-1:0]           cfg_data_i
);

  localparam int IdxW  = $clog2(WINDOW_DEPTH);
  localparam int CntW  = $clog2(WINDOW_DEPTH + 1);
  localparam int SumW  = SAMPLE_BITS + IdxW;
  localparam int DistW = (SAMPLE_BITS + 1 > ThreshW) ? SAMPLE_BITS + 1 : ThreshW;

  wmor_state_e state_q, state_d;

  logic [LenW-1:0]     len_q, len_d;
  logic [ThreshW-1:0]  thresh_q, thresh_d;
  logic [RestartW-1:0] restart_q, restart_d;

  logic [CntW-1:0]             fill_q, fill_d;
  logic [IdxW-1:0]             oldest_q, oldest_d;
  logic signed [SumW-1:0]      sum_q, sum_d;
  logic signed [SAMPLE_BITS-1:0] mean_q, mean_d;
  logic [RunW-1:0]             run_q, run_d;

  logic signed [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic acc_q, acc_d;
  logic rs_q, rs_d;
  logic full_q, full_d;

  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] out_mean_q, out_mean_d;
  logic out_acc_q, out_acc_d;
  logic out_rs_q, out_rs_d;
  logic out_full_q, out_full_d;

  logic [CntW-1:0]               eff_len;
  logic                          is_full;
  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS:0]          distance;
  logic                          near;
  logic [RunW-1:0]               run_inc;
  logic [CntW-1:0]               slot_inc;
  logic [SAMPLE_BITS-1:0]        old_sample;
  logic signed [SumW-1:0]        sample_ext;
  logic signed [SumW-1:0]        old_ext;

  logic                  ram_we;
  logic [IdxW-1:0]       ram_waddr;
  logic                  ram_re;
  logic                  in_accept;
  logic                  div_start;
  logic                  div_done;
  logic signed [SumW-1:0] div_quo;

  assign in_ready_o = (state_q == StIdle);
  assign in_accept  = in_valid_i && in_ready_o;

  // length of zero acts as one, beyond the memory acts as the memory depth
  always_comb begin
    if (len_q == '0) begin
      eff_len = CntW'(1);
    end else if (32'(len_q) > 32'(WINDOW_DEPTH)) begin
      eff_len = CntW'(WINDOW_DEPTH);
    end else begin
      eff_len = CntW'(len_q);
    end
  end

  assign is_full    = fill_q >= eff_len;
  assign diff       = {sample_q[SAMPLE_BITS-1], sample_q} - {mean_q[SAMPLE_BITS-1], mean_q};
  assign distance   = diff[SAMPLE_BITS] ?
                      (SAMPLE_BITS+1)'(-diff) : (SAMPLE_BITS+1)'(diff);
  assign near       = DistW'(distance) < DistW'(thresh_q);
  assign run_inc    = run_q + 1'b1;
  assign slot_inc   = CntW'(oldest_q) + 1'b1;
  assign sample_ext = {{IdxW{sample_q[SAMPLE_BITS-1]}}, sample_q};
  assign old_ext    = {{IdxW{old_sample[SAMPLE_BITS-1]}}, old_sample};

  assign ram_re    = in_accept;
  assign ram_we    = (state_q == StEval) && near;
  assign ram_waddr = is_full ? oldest_q : fill_q[IdxW-1:0];
  assign div_start = (state_q == StStart);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    thresh_d    = thresh_q;
    restart_d   = restart_q;
    fill_d      = fill_q;
    oldest_d    = oldest_q;
    sum_d       = sum_q;
    mean_d      = mean_q;
    run_d       = run_q;
    sample_d    = sample_q;
    acc_d       = acc_q;
    rs_d        = rs_q;
    full_d      = full_q;
    out_valid_d = out_valid_q;
    out_mean_d  = out_mean_q;
    out_acc_d   = out_acc_q;
    out_rs_d    = out_rs_q;
    out_full_d  = out_full_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          sample_d = sample_i;
          state_d  = StEval;
        end
      end
      StEval: begin
        acc_d = near;
        rs_d  = 1'b0;
        if (near) begin
          if (is_full) begin
            // replace the oldest sample, the read issued at accept
            sum_d    = sum_q + sample_ext - old_ext;
            oldest_d = (slot_inc >= eff_len) ? '0 : slot_inc[IdxW-1:0];
            run_d    = '0;
            full_d   = 1'b1;
          end else begin
            sum_d  = sum_q + sample_ext;
            fill_d = fill_q + 1'b1;
            full_d = (fill_q + 1'b1) >= eff_len;
          end
          state_d = StStart;
        end else begin
          full_d = is_full;
          if (run_inc > RunW'(restart_q)) begin
            rs_d     = 1'b1;
            fill_d   = '0;
            oldest_d = '0;
            sum_d    = '0;
            mean_d   = sample_q;
            run_d    = '0;
            full_d   = 1'b0;
          end else begin
            run_d = run_inc;
          end
          state_d = StOut;
        end
      end
      StStart: begin
        state_d = StDiv;
      end
      StDiv: begin
        if (div_done) begin
          mean_d  = div_quo[SAMPLE_BITS-1:0];
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_mean_d  = mean_q;
          out_acc_d   = acc_q;
          out_rs_d    = rs_q;
          out_full_d  = full_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // a register write starts the filter over
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgWindowLength:    len_d     = cfg_data_i[LenW-1:0];
        CfgRejectThreshold: thresh_d  = cfg_data_i[ThreshW-1:0];
        CfgRestartAfter:    restart_d = cfg_data_i[RestartW-1:0];
        default: ;
      endcase
      if (cfg_index_i == CfgWindowLength || cfg_index_i == CfgRejectThreshold ||
          cfg_index_i == CfgRestartAfter) begin
        fill_d   = '0;
        oldest_d = '0;
        sum_d    = '0;
        mean_d   = '0;
        run_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= LenReset;
      thresh_q    <= ThreshReset;
      restart_q   <= RestartReset;
      fill_q      <= '0;
      oldest_q    <= '0;
      sum_q       <= '0;
      mean_q      <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      thresh_q    <= thresh_d;
      restart_q   <= restart_d;
      fill_q      <= fill_d;
      oldest_q    <= oldest_d;
      sum_q       <= sum_d;
      mean_q      <= mean_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    acc_q      <= acc_d;
    rs_q       <= rs_d;
    full_q     <= full_d;
    out_mean_q <= out_mean_d;
    out_acc_q  <= out_acc_d;
    out_rs_q   <= out_rs_d;
    out_full_q <= out_full_d;
  end

  wmor_ram #(
    .Width (SAMPLE_BITS),
    .Depth (WINDOW_DEPTH)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sample_q),
    .re_i    (ram_re),
    .raddr_i (oldest_q),
    .rdata_o (old_sample)
  );

  wmor_div #(
    .DividendW (SumW),
    .DivisorW  (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o   = out_valid_q;
  assign mean_o        = out_mean_q;
  assign accepted_o    = out_acc_q;
  assign restarted_o   = out_rs_q;
  assign window_full_o = out_full_q;

`ifndef NO_ASSERTIONS
  // the window never holds more samples than its length
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= eff_len)
    else $error("fill count beyond window length");
  // the replace pointer stays inside the window
  assert property (@(posedge clk_i) disable iff (!rst_ni) CntW'(oldest_q) < eff_len)
    else $error("oldest index outside the window");
  // the reject run restarts before passing its limit
  assert property (@(posedge clk_i) disable iff (!rst_ni) run_q <= RunW'(restart_q))
    else $error("reject run beyond its limit");
  // a division result only arrives while waiting for it
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_done |-> state_q == StDiv)
    else $error("divider result outside the division wait");
`endif

endmodule

### test/tb_window_mean_outlier_reject_top.sv
// ----------------------------------------------------------------------------
// tb_window_mean_outlier_reject_top
// Self-checking bench for the windowed mean with outlier rejection. Samples
// go in through a bursty sender. A local model of the window predicts the
// mean and the flags of every result. A checker compares each result with
// the oldest prediction while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_window_mean_outlier_reject_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wmor_pkg::*;

  localparam int Depth     = 64;
  localparam int SampleW   = 32;
  localparam int IdleLimit = 4000;
  localparam int TailWait  = 60;
  // index 3 maps to no register
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef struct packed {
    logic signed [SampleW-1:0] mean;
    logic                      accepted;
    logic                      restarted;
    logic                      full;
  } mean_result_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] sample;
  logic                      out_valid_o;
  logic                      out_ready;
  logic signed [SampleW-1:0] mean_o;
  logic                      accepted_o;
  logic                      restarted_o;
  logic                      window_full_o;
  logic                      cfg_we;
  logic [CfgIdxW-1:0]        cfg_index;
  logic [CfgDataW-1:0]       cfg_data;

  window_mean_outlier_reject_top #(
    .WINDOW_DEPTH(Depth),
    .SAMPLE_BITS (SampleW)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .mean_o       (mean_o),
    .accepted_o   (accepted_o),
    .restarted_o  (restarted_o),
    .window_full_o(window_full_o),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  // window model
  logic signed [SampleW-1:0] win_buf [Depth];
  int unsigned               held;
  int unsigned               next_slot;
  int unsigned               miss_run;
  longint                    run_sum;
  longint                    cur_mean;
  logic [LenW-1:0]           len_reg;
  logic [ThreshW-1:0]        thr_reg;
  logic [RestartW-1:0]       restart_reg;

  mean_result_t pending_means[$];
  int           errors;
  int           items_sent;
  int           results_seen;
  int           cnt_entered;
  int           cnt_restart;
  int           cnt_full;
  int           cfg_writes;
  int           burst_left;
  int           idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_len();
    if (len_reg == 0) return 1;
    if (len_reg > Depth) return Depth;
    return len_reg;
  endfunction

  function automatic void clear_mean_model();
    held      = 0;
    next_slot = 0;
    miss_run  = 0;
    run_sum   = 0;
    cur_mean  = 0;
  endfunction

  function automatic mean_result_t step_mean_model(input logic signed [SampleW-1:0] s);
    mean_result_t r;
    longint       sv;
    longint       diff;
    longint       distance;
    longint       thr;
    int unsigned  n;
    int unsigned  slot;
    sv       = longint'(s);
    thr      = longint'(thr_reg);
    n        = eff_len();
    diff     = sv - cur_mean;
    distance = (diff < 0) ? -diff : diff;
    r        = '0;
    if (distance < thr) begin
      r.accepted = 1'b1;
      if (held >= n) begin
        slot = (next_slot >= Depth) ? 0 : next_slot;
        run_sum += sv - longint'(win_buf[slot]);
        win_buf[slot] = s;
        next_slot = (slot + 1 >= n) ? 0 : slot + 1;
        miss_run = 0;
      end else begin
        win_buf[held] = s;
        run_sum += sv;
        held++;
      end
      // signed division truncates toward zero
      cur_mean = run_sum / longint'(held);
    end else begin
      miss_run++;
      if (miss_run > restart_reg) begin
        r.restarted = 1'b1;
        clear_mean_model();
        cur_mean = sv;
      end
    end
    r.mean = cur_mean[SampleW-1:0];
    r.full = (held >= n);
    return r;
  endfunction

  // mean plus an offset, clamped to the sample range
  function automatic logic signed [SampleW-1:0] sample_at_offset(input longint delta);
    longint v;
    v = cur_mean + delta;
    if (v > longint'(2147483647)) v = longint'(2147483647);
    if (v < -longint'(2147483647) - 1) v = -longint'(2147483647) - 1;
    return v[SampleW-1:0];
  endfunction

  function automatic logic signed [SampleW-1:0] near_sample();
    longint span;
    longint off;
    span = longint'(thr_reg);
    off  = (span > 1) ? longint'($urandom_range(0, 32'(span - 1))) : 0;
    return sample_at_offset($urandom_range(0, 1) ? off : -off);
  endfunction

  function automatic logic signed [SampleW-1:0] far_sample();
    longint off;
    off = longint'(thr_reg) + longint'($urandom_range(0, 1 << 20));
    return sample_at_offset($urandom_range(0, 1) ? off : -off);
  endfunction

  task automatic send_sample(input logic signed [SampleW-1:0] s);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk_i); while (!in_ready_o);
    pending_means.push_back(step_mean_model(s));
    items_sent++;
    burst_left--;
  endtask

  task automatic wait_for_means();
    @(negedge clk_i);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_means.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    wait_for_means();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    cfg_writes++;
    case (idx)
      CfgWindowLength: begin
        len_reg = data[LenW-1:0];
        clear_mean_model();
      end
      CfgRejectThreshold: begin
        thr_reg = data[ThreshW-1:0];
        clear_mean_model();
      end
      CfgRestartAfter: begin
        restart_reg = data[RestartW-1:0];
        clear_mean_model();
      end
      default: begin
      end
    endcase
  endtask

  // reset values: fill, reject runs that build up while filling, exact
  // threshold boundary, restart
  task automatic test_fill_and_restart();
    send_sample(32'sh0000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh0000_8000);
    send_sample(32'shFFFF_FFFF);
    send_sample(sample_at_offset(longint'(thr_reg)));
    send_sample(sample_at_offset(longint'(thr_reg) - 1));
    send_sample(32'sh4000_0000);
  endtask

  // length 0 behaves as 1, upper data bits are dropped
  task automatic test_short_window();
    write_reg(CfgWindowLength, 31'h7FFF_FF00);
    send_sample(32'sh0000_0100);
    send_sample(32'sh0000_0200);
    send_sample(32'sh7000_0000);
    send_sample(32'sh0000_01F0);
    write_reg(CfgWindowLength, 31'h5555_5502);
    send_sample(sample_at_offset(longint'(16'h0100)));
    send_sample(sample_at_offset(-longint'(16'h0080)));
    send_sample(sample_at_offset(longint'(16'h0040)));
  endtask

  // length above the store depth is clamped
  task automatic test_long_window();
    write_reg(CfgWindowLength, 31'd127);
    send_sample(32'sh0000_0010);
    send_sample(32'sh0000_0020);
    write_reg(CfgWindowLength, 31'd64);
    send_sample(32'shFFFF_0000);
  endtask

  task automatic test_threshold_extremes();
    write_reg(CfgRejectThreshold, 31'd0);
    write_reg(CfgRestartAfter, 31'd0);
    send_sample(32'sh0001_2345);
    send_sample(32'sh0001_2345);
    write_reg(CfgRejectThreshold, 31'h7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(sample_at_offset(-(longint'(thr_reg) - 1)));
    send_sample(32'sh8000_0000);
    write_reg(CfgRestartAfter, 31'h0000_FFFF);
  endtask

  // a write to the spare index must leave the window alone
  task automatic test_unused_register();
    send_sample(32'sh0000_0004);
    write_reg(CfgUnused, 31'h7FFF_FFFF);
    send_sample(32'sh0000_0008);
  endtask

  task automatic test_random_phase(input int n_items, input logic [LenW-1:0] len,
                                   input logic [ThreshW-1:0] thr,
                                   input logic [RestartW-1:0] rs, input bit hold_midway);
    int i;
    int pick;
    int run_len;
    write_reg(CfgWindowLength, {24'($urandom), len});
    write_reg(CfgRejectThreshold, thr);
    write_reg(CfgRestartAfter, 31'(rs));
    i = 0;
    while (i < n_items) begin
      if (hold_midway && i == n_items / 2) wait_for_means();
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_sample(near_sample());
        i++;
      end else if (pick < 80) begin
        send_sample(far_sample());
        i++;
      end else if (pick < 90) begin
        // a run of outliers long enough to force a restart when allowed
        run_len = (rs < 10) ? rs + 1 : $urandom_range(2, 10);
        repeat (run_len) send_sample(far_sample());
        i += run_len;
      end else begin
        send_sample($urandom);
        i++;
      end
    end
  endtask

  // receiver: always ready, random ready, or blocks of stalls
  initial begin
    int mode;
    int span;
    int hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(50, 300);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: begin
            if (hold == 0) begin
              out_ready <= ~out_ready;
              hold = out_ready ? $urandom_range(1, 15) : $urandom_range(1, 5);
            end else begin
              hold--;
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    mean_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_means.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, mean %h accepted %b restarted %b full %b",
                 $time, mean_o, accepted_o, restarted_o, window_full_o);
      end else begin
        want = pending_means.pop_front();
        results_seen++;
        if (want.accepted) cnt_entered++;
        if (want.restarted) cnt_restart++;
        if (want.full) cnt_full++;
        if (mean_o !== want.mean) begin
          errors++;
          $display("%0t: mean expected %h actual %h", $time, want.mean, mean_o);
        end
        if (accepted_o !== want.accepted) begin
          errors++;
          $display("%0t: accepted expected %b actual %b", $time, want.accepted, accepted_o);
        end
        if (restarted_o !== want.restarted) begin
          errors++;
          $display("%0t: restarted expected %b actual %b", $time, want.restarted,
                   restarted_o);
        end
        if (window_full_o !== want.full) begin
          errors++;
          $display("%0t: window_full expected %b actual %b", $time, want.full,
                   window_full_o);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, IdleLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    sample       = '0;
    cfg_we       = 1'b0;
    cfg_index    = CfgWindowLength;
    cfg_data     = '0;
    idle_cycles  = 0;
    errors       = 0;
    items_sent   = 0;
    results_seen = 0;
    cnt_entered  = 0;
    cnt_restart  = 0;
    cnt_full     = 0;
    cfg_writes   = 0;
    burst_left   = 0;
    len_reg      = LenReset;
    thr_reg      = ThreshReset;
    restart_reg  = RestartReset;
    clear_mean_model();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_fill_and_restart();
    test_short_window();
    test_long_window();
    test_threshold_extremes();
    test_unused_register();

    test_random_phase(160, 7'd64, 31'd65536, 16'd3, 1'b0);
    test_random_phase(160, 7'd1, 31'($urandom_range(1, 1 << 24)), 16'd0, 1'b0);
    test_random_phase(160, 7'd2, 31'h7FFF_FFFF, 16'hFFFF, 1'b0);
    test_random_phase(150, 7'd0, 31'd1, 16'd2, 1'b0);
    test_random_phase(170, 7'd127, 31'($urandom), 16'($urandom_range(0, 8)), 1'b1);
    test_random_phase(170, 7'($urandom_range(3, 63)), 31'($urandom_range(1 << 12, 1 << 22)),
                      16'($urandom_range(0, 5)), 1'b0);
    test_random_phase(170, 7'd64, 31'($urandom_range(1 << 20, 1 << 28)), 16'hFFFF, 1'b1);
    test_random_phase(150, 7'($urandom_range(65, 126)), 31'($urandom),
                      16'($urandom_range(0, 4)), 1'b0);

    wait_for_means();
    repeat (TailWait) @(posedge clk_i);
    if (pending_means.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_means.size());
    end

    $display("run covered %0d samples, %0d results checked, %0d register writes",
             items_sent, results_seen, cfg_writes);
    $display("%0d samples entered the window, %0d restarts, %0d results with a full window",
             cnt_entered, cnt_restart, cnt_full);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### window_mean_outlier_reject_top.f
rtl/wmor_pkg.sv
rtl/wmor_ram.sv
rtl/wmor_div.sv
rtl/window_mean_outlier_reject_top.sv
test/tb_window_mean_outlier_reject_top.sv
